[sv/phc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants for the pursuit heading controller.
// No dependencies; every other file of the block imports this package.
package phc_pkg;

    // Field widths
    localparam int POS_W   = 16;                    // Q8.8 positions
    localparam int DIFF_W  = POS_W + 1;             // signed position difference
    localparam int GUARD_W = 8;                     // extra fraction bits in the rotator
    localparam int VEC_W   = 28;                    // rotator x/y width, covers CORDIC gain
    localparam int ANG_W   = 17;                    // angle accumulator, Q3.13 plus headroom
    localparam int HEAD_W  = 16;                    // heading, signed Q3.13
    localparam int ERR_W   = 16;                    // wrapped heading error
    localparam int GAIN_W  = 10;                    // turn gain, unsigned Q2.8
    localparam int GAIN_FRAC = 8;
    localparam int RATE_W  = 18;                    // turn rate output
    localparam int SPEED_W = 16;                    // forward speed, Q8.8
    localparam int SQ_W    = 2 * POS_W;             // one squared difference
    localparam int CFG_W   = 16;                    // config write data
    localparam int CFG_IDX_W = 2;

    // Angle constants in Q3.13
    localparam int PI_Q      = 25736;
    localparam int HALF_PI_Q = 12868;

    // Rotator depth
    localparam int CORDIC_STEPS_DEF = 14;
    localparam int ATAN_LEN         = 20;

    // Config register reset values
    localparam logic [SPEED_W-1:0] SPEED_RST  = SPEED_W'(512);   // 2.0
    localparam logic [GAIN_W-1:0]  GAIN_RST   = GAIN_W'(512);    // 2.0
    localparam logic [POS_W-1:0]   RADIUS_RST = POS_W'(256);     // 1.0

    // Config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD_SPEED  = 2'd0,
        CFG_TURN_GAIN      = 2'd1,
        CFG_CAPTURE_RADIUS = 2'd2
    } t_cfg_idx;

    // Rotator vector handed from cell to cell
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } t_vec;

    // Values that ride along with the vector
    typedef struct packed {
        logic signed [HEAD_W-1:0] head;
        logic                     zero;
        logic [SQ_W-1:0]          sq_x;
        logic [SQ_W-1:0]          sq_y;
    } t_side;

    // Rounded atan(2^-step) in Q3.13; zero from step 14 on
    function automatic logic signed [ANG_W-1:0] atan_q(input int step);
        logic signed [ANG_W-1:0] v;
        begin
            unique case (step)
                0:       v = ANG_W'(6434);
                1:       v = ANG_W'(3798);
                2:       v = ANG_W'(2007);
                3:       v = ANG_W'(1019);
                4:       v = ANG_W'(511);
                5:       v = ANG_W'(256);
                6:       v = ANG_W'(128);
                7:       v = ANG_W'(64);
                8:       v = ANG_W'(32);
                9:       v = ANG_W'(16);
                10:      v = ANG_W'(8);
                11:      v = ANG_W'(4);
                12:      v = ANG_W'(2);
                13:      v = ANG_W'(1);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[sv/phc_front.sv]
`timescale 1ns / 1ps
// Front end: position differences, then quadrant pre-rotation and squares.
// Depends on phc_pkg. Two pipeline registers, each with its own valid.
module phc_front
    import phc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [POS_W-1:0]  i_target_x,
    input  logic [POS_W-1:0]  i_target_y,
    input  logic [POS_W-1:0]  i_own_x,
    input  logic [POS_W-1:0]  i_own_y,
    input  logic signed [HEAD_W-1:0] i_own_heading,
    output logic              o_valid,
    input  logic              i_stall,
    output t_vec              o_vec,
    output t_side             o_side
);

    localparam int EXT_W = VEC_W - DIFF_W - GUARD_W;

    logic                     r_v1;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [HEAD_W-1:0] r_head;
    logic                     r_v2;
    t_vec                     r_vec;
    t_side                    r_side;
    t_vec                     n_vec;
    t_side                    n_side;
    logic                     stall2;
    logic                     stall1;
    logic signed [VEC_W-1:0]  gx;
    logic signed [VEC_W-1:0]  gy;
    logic signed [2*DIFF_W-1:0] sqx;
    logic signed [2*DIFF_W-1:0] sqy;

    // Hold a stage only when it is full and the next one holds
    assign stall2  = r_v2 && i_stall;
    assign stall1  = r_v1 && stall2;
    assign o_stall = stall1;

    // Stage 1: exact signed differences
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (!stall1) begin
            r_v1 <= i_valid;
        end
        if (!stall1 && i_valid) begin
            r_dx   <= DIFF_W'({1'b0, i_target_x}) - DIFF_W'({1'b0, i_own_x});
            r_dy   <= DIFF_W'({1'b0, i_target_y}) - DIFF_W'({1'b0, i_own_y});
            r_head <= i_own_heading;
        end
    end

    // Stage 2: guard bits, turn left half plane by a quarter, squares
    always_comb begin
        gx  = {{EXT_W{r_dx[DIFF_W-1]}}, r_dx, {GUARD_W{1'b0}}};
        gy  = {{EXT_W{r_dy[DIFF_W-1]}}, r_dy, {GUARD_W{1'b0}}};
        sqx = (2*DIFF_W)'(r_dx) * (2*DIFF_W)'(r_dx);
        sqy = (2*DIFF_W)'(r_dy) * (2*DIFF_W)'(r_dy);
        n_vec.x = gx;
        n_vec.y = gy;
        n_vec.z = '0;
        if (gx[VEC_W-1]) begin
            if (!gy[VEC_W-1]) begin
                n_vec.x = gy;
                n_vec.y = -gx;
                n_vec.z = ANG_W'(HALF_PI_Q);
            end else begin
                n_vec.x = -gy;
                n_vec.y = gx;
                n_vec.z = -ANG_W'(HALF_PI_Q);
            end
        end
        n_side.head = r_head;
        n_side.zero = (r_dx == '0) && (r_dy == '0);
        n_side.sq_x = sqx[SQ_W-1:0];
        n_side.sq_y = sqy[SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (!stall2) begin
            r_v2 <= r_v1;
        end
        if (!stall2 && r_v1) begin
            r_vec  <= n_vec;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v2;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

[sv/phc_cell.sv]
`timescale 1ns / 1ps
// One vectoring CORDIC iteration with its own pipeline register.
// Depends on phc_pkg for the vector types and the arctangent constants.
module phc_cell
    import phc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_vec  i_vec,
    input  t_side i_side,
    output logic  o_valid,
    input  logic  i_stall,
    output t_vec  o_vec,
    output t_side o_side
);

    localparam logic signed [ANG_W-1:0] ATAN = atan_q(STEP);

    logic                    r_valid;
    t_vec                    r_vec;
    t_side                   r_side;
    t_vec                    n_vec;
    logic signed [VEC_W-1:0] x_in;
    logic signed [VEC_W-1:0] y_in;
    logic signed [VEC_W-1:0] x_sh;
    logic signed [VEC_W-1:0] y_sh;
    logic                    y_pos;

    assign o_stall = r_valid && i_stall;

    // Rotate toward the x axis; arithmetic shift rounds toward minus infinity
    always_comb begin
        x_in  = i_vec.x;
        y_in  = i_vec.y;
        x_sh  = x_in >>> STEP;
        y_sh  = y_in >>> STEP;
        y_pos = !y_in[VEC_W-1] && (y_in != '0);
        if (y_pos) begin
            n_vec.x = x_in + y_sh;
            n_vec.y = y_in - x_sh;
            n_vec.z = i_vec.z + ATAN;
        end else begin
            n_vec.x = x_in - y_sh;
            n_vec.y = y_in + x_sh;
            n_vec.z = i_vec.z - ATAN;
        end
    end

    // Advance whenever this cell is empty or its neighbor takes the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_vec  <= n_vec;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

[sv/phc_tail.sv]
`timescale 1ns / 1ps
// Back end: heading error wrap and capture test, then gain multiply into
// the output register. Depends on phc_pkg.
module phc_tail
    import phc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_vec                 i_vec,
    input  t_side                i_side,
    input  logic [SPEED_W-1:0]   i_forward_speed,
    input  logic [GAIN_W-1:0]    i_turn_gain,
    input  logic [POS_W-1:0]     i_capture_radius,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [RATE_W-1:0] o_turn_rate,
    output logic [SPEED_W-1:0]   o_speed_out,
    output logic                 o_caught
);

    localparam int WRAP_W = ERR_W + 2;
    localparam int PROD_W = ERR_W + GAIN_W + 1;
    localparam logic signed [WRAP_W-1:0] PI_W     = WRAP_W'(PI_Q);
    localparam logic signed [WRAP_W-1:0] TWO_PI_W = WRAP_W'(2 * PI_Q);

    logic [SQ_W-1:0]           r_r2;
    logic                      r_a_valid;
    logic signed [ERR_W-1:0]   r_err;
    logic                      r_a_caught;
    logic                      r_b_valid;
    logic signed [RATE_W-1:0]  r_rate;
    logic [SPEED_W-1:0]        r_speed;
    logic                      r_caught;
    logic                      b_stall;
    logic                      a_stall;
    logic signed [WRAP_W-1:0]  bearing;
    logic signed [WRAP_W-1:0]  err_raw;
    logic signed [WRAP_W-1:0]  err_wrap;
    logic [SQ_W:0]             d2;
    logic                      n_caught;
    logic signed [PROD_W-1:0]  prod;

    assign b_stall = r_b_valid && i_stall;
    assign a_stall = r_a_valid && b_stall;
    assign o_stall = a_stall;

    // Squared capture radius follows the config register
    always_ff @(posedge i_clk) begin
        r_r2 <= SQ_W'(i_capture_radius) * SQ_W'(i_capture_radius);
    end

    // Stage A: bearing minus heading, one wrap either way; distance test
    always_comb begin
        bearing  = i_side.zero ? '0 : WRAP_W'(i_vec.z);
        err_raw  = bearing - WRAP_W'(i_side.head);
        err_wrap = err_raw;
        if (err_raw > PI_W) begin
            err_wrap = err_raw - TWO_PI_W;
        end else if (err_raw < -PI_W) begin
            err_wrap = err_raw + TWO_PI_W;
        end
        d2       = {1'b0, i_side.sq_x} + {1'b0, i_side.sq_y};
        n_caught = d2 < {1'b0, r_r2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!a_stall) begin
            r_a_valid <= i_valid;
        end
        if (!a_stall && i_valid) begin
            r_err      <= err_wrap[ERR_W-1:0];
            r_a_caught <= n_caught;
        end
    end

    // Stage B: error times gain, floor by the gain's fraction bits
    assign prod = PROD_W'(r_err) * $signed({{(PROD_W-GAIN_W){1'b0}}, i_turn_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (!b_stall) begin
            r_b_valid <= r_a_valid;
        end
        if (!b_stall && r_a_valid) begin
            r_rate   <= prod[RATE_W+GAIN_FRAC-1:GAIN_FRAC];
            r_speed  <= i_forward_speed;
            r_caught <= r_a_caught;
        end
    end

    assign o_valid     = r_b_valid;
    assign o_turn_rate = r_rate;
    assign o_speed_out = r_speed;
    assign o_caught    = r_caught;

    // Wrapped error always lies within plus or minus pi
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_err <= ERR_W'(PI_Q)) && (r_err >= -ERR_W'(PI_Q)))
        else $error("heading error outside wrap range");

    // Stage A keeps its request while the output register is held
    a_hold_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && $past(r_a_valid && r_b_valid && i_stall)) |-> $stable(r_err))
        else $error("stage A overwritten while output held");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_b_valid)
        else $error("output valid after reset");

endmodule

[sv/pursuit_heading_controller_core.sv]
`timescale 1ns / 1ps
// Top level of the pursuit heading controller: config registers, front end,
// a chain of CORDIC cells and the back end. Depends on phc_pkg and all phc_* modules.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------------------
//  input   | in        | i_valid / o_stall | i_target_x/y, i_own_x/y, i_own_heading
//  output  | out       | o_valid / i_stall | o_turn_rate, o_speed_out, o_caught
//  config  | in        | i_cfg_we          | i_cfg_index, i_cfg_data
//
// One request per cycle unless o_stall is raised; the pipeline holds two front-end stages,
// one cell per CORDIC iteration, then wrap/compare and multiply stages.
// Reset (synchronous) empties every stage and loads speed 2.0, gain 2.0, radius 1.0.
// Every stage has its own valid: a held output stalls only the stages up to the
// nearest empty one, so requests keep entering while bubbles remain.
module pursuit_heading_controller_core
    import phc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [POS_W-1:0]         i_target_x,
    input  logic [POS_W-1:0]         i_target_y,
    input  logic [POS_W-1:0]         i_own_x,
    input  logic [POS_W-1:0]         i_own_y,
    input  logic signed [HEAD_W-1:0] i_own_heading,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [RATE_W-1:0] o_turn_rate,
    output logic [SPEED_W-1:0]       o_speed_out,
    output logic                     o_caught,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    logic [SPEED_W-1:0] r_forward_speed;
    logic [GAIN_W-1:0]  r_turn_gain;
    logic [POS_W-1:0]   r_capture_radius;

    logic  c_valid [0:CORDIC_STEPS];
    logic  c_stall [0:CORDIC_STEPS];
    t_vec  c_vec   [0:CORDIC_STEPS];
    t_side c_side  [0:CORDIC_STEPS];

    // Config writes; unknown indexes drop the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward_speed  <= SPEED_RST;
            r_turn_gain      <= GAIN_RST;
            r_capture_radius <= RADIUS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FORWARD_SPEED:  r_forward_speed  <= i_cfg_data[SPEED_W-1:0];
                CFG_TURN_GAIN:      r_turn_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_CAPTURE_RADIUS: r_capture_radius <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Differences, pre-rotation and squares
    phc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_own_x       (i_own_x),
        .i_own_y       (i_own_y),
        .i_own_heading (i_own_heading),
        .o_valid       (c_valid[0]),
        .i_stall       (c_stall[0]),
        .o_vec         (c_vec[0]),
        .o_side        (c_side[0])
    );

    // One cell per CORDIC iteration
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        phc_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_stall (c_stall[k]),
            .i_vec   (c_vec[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .i_stall (c_stall[k+1]),
            .o_vec   (c_vec[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    // Wrap, capture test, gain and output register
    phc_tail u_tail (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (c_valid[CORDIC_STEPS]),
        .o_stall          (c_stall[CORDIC_STEPS]),
        .i_vec            (c_vec[CORDIC_STEPS]),
        .i_side           (c_side[CORDIC_STEPS]),
        .i_forward_speed  (r_forward_speed),
        .i_turn_gain      (r_turn_gain),
        .i_capture_radius (r_capture_radius),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_turn_rate      (o_turn_rate),
        .o_speed_out      (o_speed_out),
        .o_caught         (o_caught)
    );

endmodule
